[src/assert_macros.svh]
// Assertion macros for the point-in-triangle block.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed: implication");
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("assertion failed: invariant");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_ALWAYS(label, expr)
`endif
`endif

[src/tpc_pkg.sv]
// Shared constants for the point-in-triangle area test.
// No dependencies.
package tpc_pkg;
	localparam int COORD_W = 32;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int LIMB_W = 23;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_AREA_TOL = 1'b0;
	localparam logic [31:0] TOL_RESET = 32'd1;
	// distances: AB, BC, AC, AQ, BQ, CQ (points A=0 B=1 C=2 Q=3)
	localparam int DIST_P [6] = '{0, 1, 0, 0, 1, 2};
	localparam int DIST_Q [6] = '{1, 2, 2, 3, 3, 3};
	// Heron side sets (p, q, r): ABC, ACQ, BCQ, ABQ
	localparam int TRI_P [4] = '{0, 3, 5, 3};
	localparam int TRI_Q [4] = '{1, 5, 4, 4};
	localparam int TRI_R [4] = '{2, 2, 1, 0};
endpackage

[src/tpc_in_if.sv]
// Input channel: triangle vertices and query point.
// Depends on tpc_pkg.
interface tpc_in_if;
	logic valid;
	logic ready;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_a_x;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_a_y;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_a_z;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_b_x;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_b_y;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_b_z;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_c_x;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_c_y;
	logic signed [tpc_pkg::COORD_W-1:0] vertex_c_z;
	logic signed [tpc_pkg::COORD_W-1:0] query_x;
	logic signed [tpc_pkg::COORD_W-1:0] query_y;
	logic signed [tpc_pkg::COORD_W-1:0] query_z;
	modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
		vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y,
		query_z, input ready);
	modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
		vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y,
		query_z, output ready);
endinterface

[src/tpc_out_if.sv]
// Result channel: containment flag.
// No dependencies.
interface tpc_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

[src/triangle_point_containment_top.sv]
// Point-in-triangle test by Heron area sum, fully pipelined.
// Depends on tpc_pkg, tpc_in_if, tpc_out_if and assert_macros.svh.
//
// channel  kind        transfer when
// req      in, valid   req.valid & req.ready
// rsp      out, valid  rsp.valid & rsp.ready
// apb      cfg write   psel & penable & pwrite
//
// One item per cycle while rsp is not stalled; N = (132 - 2*COORD_FRAC_BITS) / 2
// square-root stages (one result bit each), 50 at the default.
// The whole pipe advances together; it holds while rsp is stalled.
// Reset clears valid bits and sets area_tolerance to 1.
`include "assert_macros.svh"
module triangle_point_containment_top #(
	parameter int COORD_FRAC_BITS = tpc_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tpc_in_if.sink   req,
	tpc_out_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tpc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tpc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tpc_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	localparam int CW0 = tpc_pkg::COORD_W;
	localparam int LW = tpc_pkg::LIMB_W;
	localparam int AD_W = CW0 + 1;
	localparam int HI_W = AD_W - 16;
	localparam int SQ_W = 2 * AD_W;
	localparam int DW = SQ_W;
	localparam int TW = DW + 1;
	localparam int PPW = 2 * LW;
	localparam int ROWW = 4 * LW;
	localparam int PRW = 6 * LW;
	localparam int HW = 2 * DW + 4;
	localparam int SH = 2 * COORD_FRAC_BITS + 4;
	localparam int SW = HW - 1 - SH;
	localparam int NS = (SW + 1) / 2;
	localparam int XP = 2 * NS;
	localparam int AW = NS;
	localparam int RW = AW + 2;
	localparam int CMPW = ((AW > 32) ? AW : 32) + 3;
	localparam int NV = 10 + NS;

	logic [31:0] tol_q;
	logic wr_en;
	logic adv;
	logic [NV-1:0] vld_q;
	logic out_vld_q;
	logic res_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign prdata = (paddr[2] == tpc_pkg::REG_AREA_TOL) ? tol_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tpc_pkg::TOL_RESET;
		end else if (wr_en && paddr[2] == tpc_pkg::REG_AREA_TOL) begin
			tol_q <= pwdata;
		end
	end

	assign adv = !out_vld_q || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = out_vld_q;
	assign rsp.inside_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], req.valid};
			out_vld_q <= vld_q[NV-1];
		end
	end

	// stage 1: absolute coordinate differences
	logic signed [CW0-1:0] pt [4][3];
	logic [AD_W-1:0] ad_s1 [6][3];
	always_comb begin
		pt[0][0] = req.vertex_a_x; pt[0][1] = req.vertex_a_y; pt[0][2] = req.vertex_a_z;
		pt[1][0] = req.vertex_b_x; pt[1][1] = req.vertex_b_y; pt[1][2] = req.vertex_b_z;
		pt[2][0] = req.vertex_c_x; pt[2][1] = req.vertex_c_y; pt[2][2] = req.vertex_c_z;
		pt[3][0] = req.query_x;    pt[3][1] = req.query_y;    pt[3][2] = req.query_z;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 6; d++) begin
				for (int c = 0; c < 3; c++) begin
					logic signed [AD_W-1:0] df;
					df = AD_W'(pt[tpc_pkg::DIST_P[d]][c]) - AD_W'(pt[tpc_pkg::DIST_Q[d]][c]);
					ad_s1[d][c] <= df[AD_W-1] ? AD_W'(-df) : AD_W'(df);
				end
			end
		end
	end

	// stage 2: partial products of the squares
	logic [2*HI_W-1:0] hh_s2 [6][3];
	logic [HI_W+15:0] hl_s2 [6][3];
	logic [31:0] ll_s2 [6][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 6; d++) begin
				for (int c = 0; c < 3; c++) begin
					hh_s2[d][c] <= (2*HI_W)'(ad_s1[d][c][AD_W-1:16]) * (2*HI_W)'(ad_s1[d][c][AD_W-1:16]);
					hl_s2[d][c] <= (HI_W+16)'(ad_s1[d][c][AD_W-1:16]) * (HI_W+16)'(ad_s1[d][c][15:0]);
					ll_s2[d][c] <= 32'(ad_s1[d][c][15:0]) * 32'(ad_s1[d][c][15:0]);
				end
			end
		end
	end

	// stage 3: squares
	logic [SQ_W-1:0] sq_s3 [6][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 6; d++) begin
				for (int c = 0; c < 3; c++) begin
					sq_s3[d][c] <= (SQ_W'(hh_s2[d][c]) << 32) + (SQ_W'(hl_s2[d][c]) << 17)
						+ SQ_W'(ll_s2[d][c]);
				end
			end
		end
	end

	// stage 4: squared distances
	logic [DW-1:0] ds_s4 [6];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < 6; d++) begin
				ds_s4[d] <= sq_s3[d][0] + sq_s3[d][1] + sq_s3[d][2];
			end
		end
	end

	// stage 5: Heron operands, |p + q - r|
	logic [DW-1:0] p_s5 [4];
	logic [DW-1:0] q_s5 [4];
	logic [TW-1:0] ta_s5 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 4; t++) begin
				logic signed [TW:0] tv;
				tv = (TW+1)'(ds_s4[tpc_pkg::TRI_P[t]]) + (TW+1)'(ds_s4[tpc_pkg::TRI_Q[t]])
					- (TW+1)'(ds_s4[tpc_pkg::TRI_R[t]]);
				p_s5[t] <= ds_s4[tpc_pkg::TRI_P[t]];
				q_s5[t] <= ds_s4[tpc_pkg::TRI_Q[t]];
				ta_s5[t] <= tv[TW] ? TW'(-tv) : TW'(tv);
			end
		end
	end

	// stage 6: limb products for p*q and t*t
	logic [PPW-1:0] ppq_s6 [4][3][3];
	logic [PPW-1:0] ptt_s6 [4][3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 4; t++) begin
				logic [3*LW-1:0] pa, qa, ta;
				pa = (3*LW)'(p_s5[t]);
				qa = (3*LW)'(q_s5[t]);
				ta = (3*LW)'(ta_s5[t]);
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						ppq_s6[t][i][j] <= PPW'(pa[i*LW +: LW]) * PPW'(qa[j*LW +: LW]);
						ptt_s6[t][i][j] <= PPW'(ta[i*LW +: LW]) * PPW'(ta[j*LW +: LW]);
					end
				end
			end
		end
	end

	// stage 7: row sums
	logic [ROWW-1:0] rpq_s7 [4][3];
	logic [ROWW-1:0] rtt_s7 [4][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 4; t++) begin
				for (int i = 0; i < 3; i++) begin
					rpq_s7[t][i] <= ROWW'(ppq_s6[t][i][0]) + (ROWW'(ppq_s6[t][i][1]) << LW)
						+ (ROWW'(ppq_s6[t][i][2]) << (2*LW));
					rtt_s7[t][i] <= ROWW'(ptt_s6[t][i][0]) + (ROWW'(ptt_s6[t][i][1]) << LW)
						+ (ROWW'(ptt_s6[t][i][2]) << (2*LW));
				end
			end
		end
	end

	// stage 8: full products
	logic [HW-3:0] pq_s8 [4];
	logic [HW-1:0] t2_s8 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 4; t++) begin
				logic [PRW-1:0] a, b;
				a = PRW'(rpq_s7[t][0]) + (PRW'(rpq_s7[t][1]) << LW) + (PRW'(rpq_s7[t][2]) << (2*LW));
				b = PRW'(rtt_s7[t][0]) + (PRW'(rtt_s7[t][1]) << LW) + (PRW'(rtt_s7[t][2]) << (2*LW));
				pq_s8[t] <= a[HW-3:0];
				t2_s8[t] <= b[HW-1:0];
			end
		end
	end

	// stage 9: radicand 16*T^2, clamped and scaled
	logic [XP-1:0] x_s9 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 4; t++) begin
				logic signed [HW-1:0] hx;
				hx = $signed({pq_s8[t], 2'b00}) - $signed(t2_s8[t]);
				x_s9[t] <= hx[HW-1] ? '0 : XP'(hx[HW-2:SH]);
			end
		end
	end

	// square root, one result bit per stage
	logic [XP-1:0] sqx_s [NS][4];
	logic [RW-1:0] sqr_s [NS][4];
	logic [AW-1:0] sqq_s [NS][4];
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		logic [XP-1:0] xi [4];
		logic [RW-1:0] ri [4];
		logic [AW-1:0] qi [4];
		if (k == 0) begin : g_first
			always_comb begin
				for (int t = 0; t < 4; t++) begin
					xi[t] = x_s9[t];
					ri[t] = '0;
					qi[t] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				for (int t = 0; t < 4; t++) begin
					xi[t] = sqx_s[k-1][t];
					ri[t] = sqr_s[k-1][t];
					qi[t] = sqq_s[k-1][t];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int t = 0; t < 4; t++) begin
					logic [RW-1:0] remx, trial;
					remx = {ri[t][RW-3:0], xi[t][XP-1:XP-2]};
					trial = {qi[t], 2'b01};
					sqx_s[k][t] <= {xi[t][XP-3:0], 2'b00};
					if (remx >= trial) begin
						sqr_s[k][t] <= remx - trial;
						sqq_s[k][t] <= {qi[t][AW-2:0], 1'b1};
					end else begin
						sqr_s[k][t] <= remx;
						sqq_s[k][t] <= {qi[t][AW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// area sums, then the compare into the output register
	logic [CMPW-1:0] sub_sa;
	logic [CMPW-1:0] lim_sa;
	always_ff @(posedge clk) begin
		if (adv) begin
			sub_sa <= CMPW'(sqq_s[NS-1][1]) + CMPW'(sqq_s[NS-1][2]) + CMPW'(sqq_s[NS-1][3]);
			lim_sa <= CMPW'(sqq_s[NS-1][0]) + CMPW'(tol_q);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= (sub_sa <= lim_sa);
		end
	end

	`ASSERT_IMPLIES(a_tol_write, wr_en && paddr[2] == tpc_pkg::REG_AREA_TOL, tol_q == $past(pwdata))
	`ASSERT_IMPLIES(a_stall_hold, !adv, vld_q == $past(vld_q) && out_vld_q)
	`ASSERT_ALWAYS(a_ready_or_full, req.ready || rsp.valid)
endmodule

[tb/sv/tpc_containment_checker.sv]
// Scoreboard for the point-in-triangle block: watches both channels and the
// register port, predicts each containment flag and compares in order.
// Depends on tpc_pkg, tpc_in_if and tpc_out_if.
module tpc_containment_checker #(
	parameter int FRAC_BITS = tpc_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tpc_in_if  req,
	tpc_out_if rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [tpc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tpc_pkg::APB_DATA_W-1:0] pwdata,
	output int   fail_count,
	output int   pending,
	output int   inside_seen,
	output int   outside_seen
);
	typedef logic [191:0] wide_t;
	typedef logic signed [31:0] coord_t;

	logic [31:0] tolerance;
	logic        flag_q[$];
	int          mismatches;

	function automatic wide_t side_sq(coord_t px, coord_t py, coord_t pz,
			coord_t qx, coord_t qy, coord_t qz);
		logic signed [63:0] d[3];
		logic [63:0] m;
		wide_t s;
		d[0] = 64'(px) - 64'(qx);
		d[1] = 64'(py) - 64'(qy);
		d[2] = 64'(pz) - 64'(qz);
		s = '0;
		for (int i = 0; i < 3; i++) begin
			m = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
			s = s + wide_t'(m) * wide_t'(m);
		end
		return s;
	endfunction

	function automatic logic [63:0] heron_area(wide_t p, wide_t q, wide_t r);
		wide_t t, x, c;
		logic [63:0] root;
		t = p + q - r;
		x = wide_t'(4) * p * q - t * t;
		if (x[191])
			return '0;
		x = x >> (2 * FRAC_BITS + 4);
		root = '0;
		for (int b = 62; b >= 0; b--) begin
			c = wide_t'(root | (64'd1 << b));
			if (c * c <= x)
				root = root | (64'd1 << b);
		end
		return root;
	endfunction

	function automatic logic contained(coord_t v[12], logic [31:0] tol);
		wide_t dab, dbc, dac, daq, dbq, dcq;
		logic [65:0] tri_a, sub_a;
		dab = side_sq(v[0], v[1], v[2], v[3], v[4], v[5]);
		dbc = side_sq(v[3], v[4], v[5], v[6], v[7], v[8]);
		dac = side_sq(v[0], v[1], v[2], v[6], v[7], v[8]);
		daq = side_sq(v[0], v[1], v[2], v[9], v[10], v[11]);
		dbq = side_sq(v[3], v[4], v[5], v[9], v[10], v[11]);
		dcq = side_sq(v[6], v[7], v[8], v[9], v[10], v[11]);
		tri_a = 66'(heron_area(dab, dbc, dac));
		sub_a = 66'(heron_area(daq, dcq, dac)) + 66'(heron_area(dcq, dbq, dbc))
			+ 66'(heron_area(daq, dbq, dab));
		return sub_a <= tri_a + 66'(tol);
	endfunction

	assign pending = flag_q.size();

	always @(posedge clk or negedge arst_n) begin
		coord_t v[12];
		logic exp_flag;
		if (!arst_n) begin
			tolerance = tpc_pkg::TOL_RESET;
			flag_q.delete();
			fail_count = 0;
			mismatches = 0;
			inside_seen = 0;
			outside_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 0)
				tolerance = pwdata;
			if (req.valid && req.ready) begin
				v = '{req.vertex_a_x, req.vertex_a_y, req.vertex_a_z,
					req.vertex_b_x, req.vertex_b_y, req.vertex_b_z,
					req.vertex_c_x, req.vertex_c_y, req.vertex_c_z,
					req.query_x, req.query_y, req.query_z};
				flag_q.push_back(contained(v, tolerance));
			end
			if (rsp.valid && rsp.ready) begin
				if (flag_q.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10)
						$display("unexpected result transfer: inside_res=%b",
							rsp.inside_res);
				end else begin
					exp_flag = flag_q.pop_front();
					if (exp_flag) inside_seen++; else outside_seen++;
					if (rsp.inside_res !== exp_flag) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("inside_res mismatch: expected %b, got %b",
								exp_flag, rsp.inside_res);
					end
				end
			end
		end
	end
endmodule

[tb/sv/triangle_point_containment_top_test.sv]
// Stimulus and verdict for the point-in-triangle block: directed and random
// triangles, tolerance phases over the register port, random idling and stalls.
// Depends on tpc_pkg, the channel interfaces, the block and tpc_containment_checker.
module triangle_point_containment_top_test;
	localparam int LIMIT = 400000;
	localparam int DRAIN = 80;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [tpc_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [tpc_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [tpc_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	int fail_count, pending, inside_seen, outside_seen;
	int cycles = 0;
	int sent = 0;
	logic calm_tx = 0, calm_rx = 0, hold_go = 0;

	tpc_in_if  req();
	tpc_out_if rsp();

	triangle_point_containment_top dut (
		.clk, .arst_n, .req(req.sink), .rsp(rsp.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	tpc_containment_checker chk (
		.clk, .arst_n, .req, .rsp, .psel, .penable, .pwrite, .pready,
		.paddr, .pwdata, .fail_count, .pending, .inside_seen, .outside_seen
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** triangle_point_containment_top: FAILED **");
			$finish;
		end
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		int hold;
		logic held;
		hold = 0;
		held = 0;
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				rsp.ready <= 0;
			end else if (calm_rx)
				rsp.ready <= 1;
			else
				rsp.ready <= $urandom_range(99) >= 26;
		end
	end

	task automatic reg_write(int idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= tpc_pkg::APB_ADDR_W'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send(logic [31:0] v[12]);
		while (!calm_tx && $urandom_range(99) < 26) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.vertex_a_x <= v[0]; req.vertex_a_y <= v[1]; req.vertex_a_z <= v[2];
		req.vertex_b_x <= v[3]; req.vertex_b_y <= v[4]; req.vertex_b_z <= v[5];
		req.vertex_c_x <= v[6]; req.vertex_c_y <= v[7]; req.vertex_c_z <= v[8];
		req.query_x <= v[9]; req.query_y <= v[10]; req.query_z <= v[11];
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	function automatic logic [31:0] rnd_span(int bits);
		logic signed [31:0] r;
		r = $signed($urandom) >>> (32 - bits);
		return r;
	endfunction

	// triangle with query point near its plane region: inside, on edge or beyond
	task automatic send_shaped();
		logic [31:0] v[12];
		int bits, u, w, sc;
		logic signed [63:0] base, e1, e2;
		bits = $urandom_range(28, 4);
		for (int i = 0; i < 9; i++)
			v[i] = rnd_span(bits);
		sc = ($urandom_range(3) == 0) ? 300 : 256;
		u = $urandom_range(sc);
		w = $urandom_range(sc - u);
		if ($urandom_range(9) == 0) u = sc;
		for (int k = 0; k < 3; k++) begin
			base = $signed(v[k]);
			e1 = $signed(v[3 + k]) - base;
			e2 = $signed(v[6 + k]) - base;
			v[9 + k] = 32'(base + (e1 * u + e2 * w) / 256 + $signed($urandom_range(2)) - 1);
		end
		send(v);
	endtask

	task automatic send_noise();
		logic [31:0] v[12];
		for (int i = 0; i < 12; i++)
			v[i] = $urandom;
		send(v);
	endtask

	task automatic directed();
		logic [31:0] v[12];
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		for (int i = 0; i < 12; i++) v[i] = mx;
		send(v);
		for (int i = 0; i < 12; i++) v[i] = mn;
		send(v);
		v = '{mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn};
		send(v);
		v = '{mn, mn, mn, mx, mx, mx, mx, mn, mn, 0, 0, 0};
		send(v);
		v = '{mn, 0, 0, mx, 0, 0, 0, mx, 0, 0, mn, mx};
		send(v);
		// small unit triangle, point inside, on vertex, on edge, outside
		v = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 32'h4000, 32'h4000, 0};
		send(v);
		v[9] = 0; v[10] = 0; send(v);
		v[9] = 32'h8000; v[10] = 32'h8000; send(v);
		v[9] = 32'h10000; v[10] = 32'h10000; send(v);
		v[11] = 32'h100; v[9] = 32'h4000; v[10] = 32'h4000; send(v);
		// collinear and coincident vertices
		v = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000,
			32'h8000, 32'h8000, 32'h8000};
		send(v);
		v[9] = 32'h30000; send(v);
		v[9] = 0; v[10] = 32'h10000; send(v);
		v = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5};
		send(v);
		v[9] = 6; send(v);
		v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mn, mn, mn};
		send(v);
		v = '{mx, 0, 0, mn, 0, 0, mx, 0, 0, 0, 0, 0};
		send(v);
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};
		send(v);
		v = '{mn, mn, 0, mx, mn, 0, 0, mx, 0, 0, 0, mx};
		send(v);
		v = '{32'hffffffff, 0, 0, 1, 0, 0, 0, 32'hffffffff, 0, 0, 0, 32'hffffffff};
		send(v);
	endtask

	task automatic random_batch(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80) send_shaped();
			else send_noise();
		end
	endtask

	initial begin
		req.valid = 0;
		req.vertex_a_x = 0; req.vertex_a_y = 0; req.vertex_a_z = 0;
		req.vertex_b_x = 0; req.vertex_b_y = 0; req.vertex_b_z = 0;
		req.vertex_c_x = 0; req.vertex_c_y = 0; req.vertex_c_z = 0;
		req.query_x = 0; req.query_y = 0; req.query_z = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		directed();
		random_batch(250);
		req.valid <= 0;
		drain();

		reg_write(0, 32'd0);
		reg_write(1, 32'h12345678);
		directed();
		random_batch(250);
		// fill the pipe against a stalled receiver
		hold_go <= 1;
		random_batch(150);
		req.valid <= 0;
		drain();

		reg_write(0, 32'hffffffff);
		directed();
		random_batch(200);
		req.valid <= 0;
		drain();

		reg_write(0, 32'h00010000);
		calm_tx <= 1;
		calm_rx <= 1;
		random_batch(300);
		calm_tx <= 0;
		calm_rx <= 0;
		req.valid <= 0;
		drain();

		reg_write(0, $urandom_range(255));
		random_batch(390);
		req.valid <= 0;
		drain();

		$display("%0d items sent over five tolerance settings, extremes included", sent);
		$display("results: %0d inside, %0d outside", inside_seen, outside_seen);
		if (fail_count == 0)
			$display("** triangle_point_containment_top: PASSED **");
		else
			$display("** triangle_point_containment_top: FAILED **");
		$finish;
	end
endmodule
